// ----- rtl/mtd_pkg.sv -----
// types, constants and helpers shared by the track event decoder modules
package mtd_pkg;

	// result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	// byte codes of the track format
	localparam logic [7:0] ST_SYSEX      = 8'hF0;
	localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
	localparam logic [7:0] ST_META       = 8'hFF;
	localparam logic [7:0] META_EOT      = 8'h2F;
	localparam logic [7:0] META_TEMPO    = 8'h51;
	localparam logic [3:0] HI_POLY_AT    = 4'hA;
	localparam logic [3:0] HI_PROGRAM    = 4'hC;
	localparam logic [3:0] HI_CHAN_AT    = 4'hD;
	localparam logic [3:0] HI_SYSTEM     = 4'hF;
	localparam logic [2:0] VLQ_MAX_BYTES = 3'd4;
	localparam logic [27:0] TEMPO_LEN    = 28'd3;

	// result kinds
	typedef enum logic [1:0] {
		KIND_CHANNEL = 2'd0,
		KIND_TEMPO   = 2'd1,
		KIND_END     = 2'd2
	} kind_t;

	// track end causes
	typedef enum logic [1:0] {
		END_EOT       = 2'd0,
		END_NO_BYTES  = 2'd1,
		END_MALFORMED = 2'd2
	} cause_t;

	// parser phases, one-hot
	typedef enum logic [8:0] {
		PH_DELTA    = 9'b000000001,
		PH_STATUS   = 9'b000000010,
		PH_DATA1    = 9'b000000100,
		PH_DATA2    = 9'b000001000,
		PH_SYSLEN   = 9'b000010000,
		PH_SYSSKIP  = 9'b000100000,
		PH_METATYPE = 9'b001000000,
		PH_METALEN  = 9'b010000000,
		PH_METASKIP = 9'b100000000
	} phase_t;

	// one input item
	typedef struct packed {
		logic [7:0] track_byte;
		logic       last_of_chunk;
	} mtd_item_t;

	// one result item
	typedef struct packed {
		kind_t       kind;
		logic [31:0] event_tick;
		logic [7:0]  status_byte;
		logic [6:0]  data_first;
		logic [6:0]  data_second;
		logic [23:0] tempo_us;
		cause_t      end_cause;
		logic        final_of_run;
	} mtd_result_t;

	// results produced by one item, in order
	typedef struct packed {
		logic [1:0]  count;
		mtd_result_t first;
		mtd_result_t second;
	} mtd_push_t;

	// assemble a result with the final flag cleared
	function automatic mtd_result_t mk_result(kind_t k, logic [31:0] tick, logic [7:0] st,
			logic [6:0] a, logic [6:0] b, logic [23:0] tempo, cause_t cause);
		mtd_result_t r;
		r.kind         = k;
		r.event_tick   = tick;
		r.status_byte  = st;
		r.data_first   = a;
		r.data_second  = b;
		r.tempo_us     = tempo;
		r.end_cause    = cause;
		r.final_of_run = 1'b0;
		return r;
	endfunction

endpackage

// ----- rtl/mtd_input_stage.sv -----
// input register holding one track byte between the slave port and the parser
module mtd_input_stage import mtd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] track_byte
	input  logic       s_axis_tlast,   // last_of_chunk
	input  logic       take,
	output logic       item_valid,
	output mtd_item_t  item
);

	logic      valid_s1;
	mtd_item_t item_s1;

	// refill whenever empty or the held item is consumed this cycle
	assign s_axis_tready = !valid_s1 || take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.track_byte    <= s_axis_tdata;
			item_s1.last_of_chunk <= s_axis_tlast;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ----- rtl/mtd_decode_core.sv -----
// parser state and per-byte decode of track events
module mtd_decode_core import mtd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  mtd_item_t item,
	output mtd_push_t results
);

	phase_t      phase_q, ph_n;
	logic [7:0]  run_status_q, run_n;
	logic [31:0] tick_q, tick_n;
	logic [27:0] vlq_acc_q, acc_n;
	logic [2:0]  vlq_cnt_q, cnt_n;
	logic [27:0] pay_left_q, left_n;
	logic [7:0]  meta_kind_q, meta_n;
	logic [7:0]  held_status_q, hst_n;
	logic [6:0]  held_data_q, hdat_n;
	logic [23:0] tempo_q, tempo_n;
	logic        dead_q, dead_n;

	logic        ev_v, end_v, clr;
	kind_t       ev_kind;
	logic [7:0]  ev_st;
	logic [6:0]  ev_a, ev_b;
	logic [23:0] ev_tempo;
	cause_t      cause;

	// next state and results for the held byte
	always_comb begin
		logic [7:0]  b;
		logic        last;
		logic [27:0] acc_feed;
		logic [2:0]  cnt_feed;
		logic        feed_over;
		logic [27:0] left_dec;
		logic [7:0]  st_sel;
		logic [23:0] tempo_shift;
		logic        one_byte;
		logic        drop;
		mtd_result_t r_ev, r_end;

		b           = item.track_byte;
		last        = item.last_of_chunk;
		acc_feed    = {vlq_acc_q[20:0], b[6:0]};
		cnt_feed    = vlq_cnt_q + 3'd1;
		feed_over   = b[7] && (cnt_feed >= VLQ_MAX_BYTES);
		left_dec    = pay_left_q - 28'd1;
		st_sel      = b[7] ? b : run_status_q;
		tempo_shift = {tempo_q[15:0], b};
		one_byte    = (st_sel[7:4] == HI_PROGRAM) || (st_sel[7:4] == HI_CHAN_AT);

		ph_n     = phase_q;
		run_n    = run_status_q;
		tick_n   = tick_q;
		acc_n    = vlq_acc_q;
		cnt_n    = vlq_cnt_q;
		left_n   = pay_left_q;
		meta_n   = meta_kind_q;
		hst_n    = held_status_q;
		hdat_n   = held_data_q;
		tempo_n  = tempo_q;
		dead_n   = dead_q;
		ev_v     = 1'b0;
		ev_kind  = KIND_CHANNEL;
		ev_st    = 8'd0;
		ev_a     = 7'd0;
		ev_b     = 7'd0;
		ev_tempo = 24'd0;
		end_v    = 1'b0;
		cause    = END_EOT;
		clr      = 1'b0;
		drop     = 1'b0;

		if (dead_q) begin
			// skip the rest of a chunk after an early end
			clr = last;
		end else begin
			unique case (phase_q)
				PH_DELTA: begin
					acc_n = acc_feed;
					cnt_n = cnt_feed;
					if (feed_over) begin
						end_v = 1'b1;
						cause = END_MALFORMED;
					end else if (!b[7]) begin
						tick_n = tick_q + {4'd0, acc_feed};
						ph_n   = PH_STATUS;
					end
				end
				PH_STATUS: begin
					if (!b[7] && !run_status_q[7]) begin
						end_v = 1'b1;
						cause = END_MALFORMED;
					end else if (st_sel[7] && st_sel[7:4] != HI_SYSTEM) begin
						run_n = st_sel;
						hst_n = st_sel;
						if (b[7]) begin
							ph_n = PH_DATA1;
						end else if (one_byte) begin
							ph_n  = PH_DELTA;
							acc_n = 28'd0;
							cnt_n = 3'd0;
							ev_v  = (st_sel[7:4] != HI_CHAN_AT);
							ev_st = st_sel;
							ev_a  = b[6:0];
						end else begin
							hdat_n = b[6:0];
							ph_n   = PH_DATA2;
						end
					end else if (st_sel == ST_SYSEX || st_sel == ST_SYSEX_ESC) begin
						run_n = 8'd0;
						acc_n = 28'd0;
						cnt_n = 3'd0;
						ph_n  = PH_SYSLEN;
					end else if (st_sel == ST_META) begin
						run_n = 8'd0;
						ph_n  = PH_METATYPE;
					end else begin
						end_v = 1'b1;
						cause = END_MALFORMED;
					end
				end
				PH_DATA1: begin
					if (held_status_q[7:4] == HI_PROGRAM || held_status_q[7:4] == HI_CHAN_AT) begin
						ph_n  = PH_DELTA;
						acc_n = 28'd0;
						cnt_n = 3'd0;
						ev_v  = (held_status_q[7:4] != HI_CHAN_AT);
						ev_st = held_status_q;
						ev_a  = b[6:0];
					end else begin
						hdat_n = b[6:0];
						ph_n   = PH_DATA2;
					end
				end
				PH_DATA2: begin
					drop  = (held_status_q[7:4] == HI_POLY_AT)
						|| (held_status_q[7:4] == HI_CHAN_AT);
					ph_n  = PH_DELTA;
					acc_n = 28'd0;
					cnt_n = 3'd0;
					ev_v  = !drop;
					ev_st = held_status_q;
					ev_a  = held_data_q;
					ev_b  = b[6:0];
				end
				PH_SYSLEN: begin
					acc_n = acc_feed;
					cnt_n = cnt_feed;
					if (feed_over) begin
						end_v = 1'b1;
						cause = END_MALFORMED;
					end else if (!b[7]) begin
						left_n = acc_feed;
						if (acc_feed == 28'd0) begin
							ph_n  = PH_DELTA;
							acc_n = 28'd0;
							cnt_n = 3'd0;
						end else begin
							ph_n = PH_SYSSKIP;
						end
					end
				end
				PH_SYSSKIP: begin
					left_n = left_dec;
					if (left_dec == 28'd0) begin
						ph_n  = PH_DELTA;
						acc_n = 28'd0;
						cnt_n = 3'd0;
					end
				end
				PH_METATYPE: begin
					meta_n = b;
					acc_n  = 28'd0;
					cnt_n  = 3'd0;
					ph_n   = PH_METALEN;
				end
				PH_METALEN: begin
					acc_n = acc_feed;
					cnt_n = cnt_feed;
					if (feed_over) begin
						end_v = 1'b1;
						cause = END_MALFORMED;
					end else if (!b[7]) begin
						left_n  = acc_feed;
						tempo_n = 24'd0;
						if (acc_feed == 28'd0) begin
							// empty meta: only end of track matters
							if (meta_kind_q == META_EOT) begin
								end_v = 1'b1;
								cause = END_EOT;
							end else begin
								ph_n  = PH_DELTA;
								acc_n = 28'd0;
								cnt_n = 3'd0;
							end
						end else begin
							ph_n = PH_METASKIP;
						end
					end
				end
				PH_METASKIP: begin
					tempo_n = tempo_shift;
					left_n  = left_dec;
					if (left_dec == 28'd0) begin
						if (meta_kind_q == META_EOT) begin
							end_v = 1'b1;
							cause = END_EOT;
						end else begin
							ev_v     = (meta_kind_q == META_TEMPO) && (vlq_acc_q == TEMPO_LEN)
								&& (tempo_shift != 24'd0);
							ev_kind  = KIND_TEMPO;
							ev_st    = ST_META;
							ev_tempo = tempo_shift;
							ph_n     = PH_DELTA;
							acc_n    = 28'd0;
							cnt_n    = 3'd0;
						end
					end
				end
				default: begin
					end_v = 1'b1;
					cause = END_MALFORMED;
				end
			endcase

			// last byte ends the track unless it already ended
			if (!end_v && last) begin
				end_v = 1'b1;
				cause = END_NO_BYTES;
			end
			clr    = end_v;
			dead_n = end_v ? !last : dead_q;
		end

		// result assembly uses the tick before any clear
		r_ev  = mk_result(ev_kind, tick_n, ev_st, ev_a, ev_b, ev_tempo, END_EOT);
		r_end = mk_result(KIND_END, tick_n, 8'd0, 7'd0, 7'd0, 24'd0, cause);
		results.second = r_end;
		results.second.final_of_run = 1'b1;
		if (ev_v) begin
			results.first = r_ev;
			results.first.final_of_run = !end_v;
			results.count = end_v ? 2'd2 : 2'd1;
		end else begin
			results.first = r_end;
			results.first.final_of_run = 1'b1;
			results.count = end_v ? 2'd1 : 2'd0;
		end

		// track end resets all state but the skip flag
		if (clr) begin
			ph_n    = PH_DELTA;
			run_n   = 8'd0;
			tick_n  = 32'd0;
			acc_n   = 28'd0;
			cnt_n   = 3'd0;
			left_n  = 28'd0;
			meta_n  = 8'd0;
			hst_n   = 8'd0;
			hdat_n  = 7'd0;
			tempo_n = 24'd0;
			if (dead_q) begin
				dead_n = 1'b0;
			end
		end

		if (!fire) begin
			results.count = 2'd0;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_DELTA;
			run_status_q  <= 8'd0;
			tick_q        <= 32'd0;
			vlq_acc_q     <= 28'd0;
			vlq_cnt_q     <= 3'd0;
			pay_left_q    <= 28'd0;
			meta_kind_q   <= 8'd0;
			held_status_q <= 8'd0;
			held_data_q   <= 7'd0;
			tempo_q       <= 24'd0;
			dead_q        <= 1'b0;
		end else if (fire) begin
			phase_q       <= ph_n;
			run_status_q  <= run_n;
			tick_q        <= tick_n;
			vlq_acc_q     <= acc_n;
			vlq_cnt_q     <= cnt_n;
			pay_left_q    <= left_n;
			meta_kind_q   <= meta_n;
			held_status_q <= hst_n;
			held_data_q   <= hdat_n;
			tempo_q       <= tempo_n;
			dead_q        <= dead_n;
		end
	end

	// a skipped remainder of a chunk gives no results
	a_dead_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && dead_q) |-> (results.count == 2'd0))
		else $error("results produced while skipping a dead chunk");

	// the last byte of a live chunk always ends the track
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !dead_q && item.last_of_chunk) |-> (results.count != 2'd0))
		else $error("last byte of chunk gave no end result");

	// after the last byte the parser is ready for a fresh track
	a_last_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.last_of_chunk) |=> (!dead_q && phase_q == PH_DELTA && tick_q == 32'd0))
		else $error("state not cleared after last byte of chunk");

endmodule

// ----- rtl/mtd_result_fifo.sv -----
// small result queue taking up to two results per cycle and feeding the master port
module mtd_result_fifo import mtd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mtd_push_t   push,
	output logic        room,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // event_tick, status_byte, data_first, data_second,
	                                   // tempo_us, end_cause
	output logic [1:0]  m_axis_tuser,  // [1:0] kind
	output logic        m_axis_tlast   // final_of_run
);

	typedef logic [FIFO_AW-1:0] ptr_t;
	typedef logic [FIFO_CW-1:0] cnt_t;

	mtd_result_t mem [FIFO_DEPTH];
	ptr_t        wr_q, rd_q;
	cnt_t        cnt_q;
	logic        pop;
	mtd_result_t head;

	// two free slots are needed to take a byte
	assign room = (cnt_q <= cnt_t'(FIFO_DEPTH - 2));
	assign pop  = m_axis_tvalid && m_axis_tready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + ptr_t'(push.count);
			rd_q  <= rd_q + ptr_t'(pop);
			cnt_q <= cnt_q + cnt_t'(push.count) - cnt_t'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem[wr_q + ptr_t'(1)] <= push.second;
		end
	end

	// head of queue onto the master port
	assign head          = mem[rd_q];
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = {head.end_cause, head.tempo_us, head.data_second, head.data_first,
		head.status_byte, head.event_tick};
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.final_of_run;

	// a pair of results never overruns the queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (cnt_q <= cnt_t'(FIFO_DEPTH - 2)))
		else $error("result queue overrun");

	// a drain with nothing new lowers the fill level by one
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.count == 2'd0) |=> (cnt_q == $past(cnt_q) - cnt_t'(1)))
		else $error("fill level wrong after drain");

	// in a pair only the second result closes the run
	a_pair_final: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (push.second.final_of_run && !push.first.final_of_run))
		else $error("final flag misplaced in result pair");

endmodule

// ----- rtl/midi_track_event_decoder_unit.sv -----
// top level of the track event decoder: input register, parser, result queue
//
//  channel   dir  tdata                                        tuser      tlast
//  s_axis    in   [7:0] track_byte                             -          last_of_chunk
//  m_axis    out  [31:0] event_tick [39:32] status_byte        [1:0] kind final_of_run
//                 [46:40] data_first [53:47] data_second
//                 [77:54] tempo_us [79:78] end_cause
//
//  one byte is taken per cycle while the queue has room; each byte passes the input register
//  a byte may give two results (event plus track end); the master port moves one per cycle
//  if ready; the four-entry result queue sets how far the input may run ahead of the output
//  the parser takes a byte only while the queue has two free entries
//  arst_n clears the parser to the start of a track and empties the queue
module midi_track_event_decoder_unit import mtd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] track_byte
	input  logic        s_axis_tlast,   // last_of_chunk
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // [31:0] event_tick, [39:32] status_byte,
	                                    // [46:40] data_first, [53:47] data_second,
	                                    // [77:54] tempo_us, [79:78] end_cause
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast    // final_of_run
);

	logic      item_valid;
	mtd_item_t item;
	logic      room;
	logic      fire;
	mtd_push_t results;

	// parse the held byte when the queue can take its results
	assign fire = item_valid && room;

	mtd_input_stage u_input (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.take          (fire),
		.item_valid    (item_valid),
		.item          (item)
	);

	mtd_decode_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item),
		.results (results)
	);

	mtd_result_fifo u_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (results),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
